// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the event stream parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Clocked assertion that is checked in reset as well.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/core/xesp_pkg.sv -----
// ----------------------------------------------------------------------------
// xesp_pkg
// Types, codes and constants shared by the extended MIDI event stream parser.
// ----------------------------------------------------------------------------
package xesp_pkg;

  // Widths and queue sizing.
  localparam int unsigned PosBits      = 24;
  localparam int unsigned LenBits      = 24;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

  // Byte values of the event stream.
  localparam logic [7:0] ByteMeta      = 8'hFF;
  localparam logic [7:0] ByteDelayCont = 8'h7F;
  localparam logic [7:0] MetaText      = 8'h21;
  localparam logic [7:0] MetaEnd       = 8'h2F;
  localparam logic [7:0] MetaTempo     = 8'h51;
  localparam logic [7:0] MetaOffset    = 8'h54;
  localparam logic [7:0] MetaTimeSig   = 8'h58;
  localparam logic [7:0] MetaKeySig    = 8'h59;

  // Command nibbles that are understood.
  localparam logic [3:0] CmdNote    = 4'h9;
  localparam logic [3:0] CmdCtl     = 4'hB;
  localparam logic [3:0] CmdProgram = 4'hC;
  localparam logic [3:0] CmdBend    = 4'hE;

  // Result kinds.
  typedef enum logic [3:0] {
    KIND_CTL     = 4'd0,
    KIND_BEND    = 4'd1,
    KIND_PROGRAM = 4'd2,
    KIND_NOTE_ON = 4'd3,
    KIND_DELAY   = 4'd4,
    KIND_TEMPO   = 4'd5,
    KIND_END     = 4'd6,
    KIND_META    = 4'd7,
    KIND_SHORT   = 4'd8,
    KIND_ERROR   = 4'd9
  } kind_e;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PH_STATUS = 8'b0000_0001,
    PH_FIRST  = 8'b0000_0010,
    PH_SECOND = 8'b0000_0100,
    PH_DUR    = 8'b0000_1000,
    PH_MTYPE  = 8'b0001_0000,
    PH_MSIZE  = 8'b0010_0000,
    PH_MDATA  = 8'b0100_0000,
    PH_DELAY  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [31:0] value;
  } result_t;

  // One queue entry holds the one or two results caused by a byte.
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } entry_t;

  typedef struct packed {
    logic       known;
    logic [7:0] size;
  } meta_size_t;

  // Expected payload size of the known meta event types.
  function automatic meta_size_t meta_size(input logic [7:0] mtype);
    meta_size_t r;
    r.known = 1'b1;
    case (mtype)
      MetaText:    r.size = 8'd1;
      MetaEnd:     r.size = 8'd0;
      MetaTempo:   r.size = 8'd3;
      MetaOffset:  r.size = 8'd5;
      MetaTimeSig: r.size = 8'd4;
      MetaKeySig:  r.size = 8'd2;
      default: begin
        r.known = 1'b0;
        r.size  = 8'd0;
      end
    endcase
    return r;
  endfunction

  function automatic result_t make_result(input kind_e kind, input logic [3:0] ch,
                                          input logic [7:0] a, input logic [7:0] b,
                                          input logic [31:0] v);
    result_t r;
    r.kind        = kind;
    r.channel     = ch;
    r.first_data  = a;
    r.second_data = b;
    r.value       = v;
    return r;
  endfunction

endpackage

// ----- rtl/core/xesp_front.sv -----
// ----------------------------------------------------------------------------
// xesp_front
// Byte-level decoder: one byte per cycle while the queue has room; tracks the
// parse phase and pushes the results caused by each byte as one queue entry.
// ----------------------------------------------------------------------------
module xesp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [23:0]            sequence_length_i,
  input  logic                   in_valid_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   start_of_sequence_i,
  input  logic                   q_full_i,
  output logic                   in_stall_o,
  output logic                   push_o,
  output xesp_pkg::entry_t       entry_o
);

  logic [xesp_pkg::LenBits-1:0] len_q;
  logic [xesp_pkg::PosBits-1:0] pos_q, pos_d, pos_s, pos_inc;
  xesp_pkg::phase_e             phase_q, phase_d, phase_s;
  logic [3:0]                   cmd_q, cmd_d, chan_q, chan_d;
  logic [7:0]                   first_q, first_d, second_q, second_d;
  logic [31:0]                  acc_q, acc_d, acc_sum, acc_dur, acc_meta;
  logic [7:0]                   mleft_q, mleft_d, mleft_dec;
  logic                         fin_q, fin_d, fin_s;
  logic                         accept;
  logic                         do_status;
  logic                         a_v, b_v;
  xesp_pkg::result_t            res_a, res_b;
  logic [31:0]                  len32, pos32, pos_inc32, left32;
  xesp_pkg::meta_size_t         msz;
  logic [7:0]                   b;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign b          = data_byte_i;

  // Start of sequence clears position, phase and the finished flag first.
  assign pos_s   = start_of_sequence_i ? '0 : pos_q;
  assign phase_s = start_of_sequence_i ? xesp_pkg::PH_STATUS : phase_q;
  assign fin_s   = start_of_sequence_i ? 1'b0 : fin_q;

  // Saturating position advance and widened compare operands.
  assign pos_inc   = (&pos_s) ? pos_s : pos_s + 1'b1;
  assign len32     = 32'(len_q);
  assign pos32     = 32'(pos_s);
  assign pos_inc32 = 32'(pos_inc);
  assign left32    = len32 - pos32;

  assign acc_sum   = acc_q + 32'(b);
  assign acc_dur   = {acc_q[24:0], b[6:0]};
  assign acc_meta  = {acc_q[23:0], b};
  assign mleft_dec = (mleft_q != 8'd0) ? mleft_q - 8'd1 : 8'd0;
  assign msz       = xesp_pkg::meta_size(first_q);

  // Phase decoder.
  always_comb begin
    pos_d     = pos_s;
    phase_d   = phase_s;
    fin_d     = fin_s;
    cmd_d     = cmd_q;
    chan_d    = chan_q;
    first_d   = first_q;
    second_d  = second_q;
    acc_d     = acc_q;
    mleft_d   = mleft_q;
    do_status = 1'b0;
    a_v       = 1'b0;
    b_v       = 1'b0;
    res_a     = xesp_pkg::make_result(xesp_pkg::KIND_DELAY, 4'd0, 8'd0, 8'd0, acc_q);
    res_b     = xesp_pkg::make_result(xesp_pkg::KIND_SHORT, 4'd0, 8'd0, 8'd0, 32'd0);

    if (!fin_s) begin
      case (phase_s)
        xesp_pkg::PH_DELAY: begin
          if (pos32 >= len32) begin
            a_v   = (acc_q != 32'd0);
            fin_d = 1'b1;
          end else if (b[7]) begin
            // A status byte ends the delay and is decoded in the same cycle.
            a_v       = (acc_q != 32'd0);
            phase_d   = xesp_pkg::PH_STATUS;
            do_status = 1'b1;
          end else begin
            acc_d = acc_sum;
            pos_d = pos_inc;
            res_a = xesp_pkg::make_result(xesp_pkg::KIND_DELAY, 4'd0, 8'd0, 8'd0,
                                          acc_sum);
            if (!(b == xesp_pkg::ByteDelayCont && pos_inc32 < len32)) begin
              a_v     = (acc_sum != 32'd0);
              phase_d = xesp_pkg::PH_STATUS;
            end
          end
        end
        xesp_pkg::PH_FIRST: begin
          first_d = b;
          pos_d   = pos_inc;
          if (cmd_q == xesp_pkg::CmdProgram) begin
            a_v     = 1'b1;
            res_a   = xesp_pkg::make_result(xesp_pkg::KIND_PROGRAM, chan_q, b, 8'd0,
                                            32'd0);
            acc_d   = 32'd0;
            phase_d = xesp_pkg::PH_DELAY;
          end else begin
            phase_d = xesp_pkg::PH_SECOND;
          end
        end
        xesp_pkg::PH_SECOND: begin
          second_d = b;
          pos_d    = pos_inc;
          acc_d    = 32'd0;
          if (cmd_q == xesp_pkg::CmdNote) begin
            phase_d = xesp_pkg::PH_DUR;
          end else begin
            a_v     = 1'b1;
            res_a   = xesp_pkg::make_result(
                        (cmd_q == xesp_pkg::CmdCtl) ? xesp_pkg::KIND_CTL
                                                    : xesp_pkg::KIND_BEND,
                        chan_q, first_q, b, 32'd0);
            phase_d = xesp_pkg::PH_DELAY;
          end
        end
        xesp_pkg::PH_DUR: begin
          pos_d = pos_inc;
          if (!(b[7] && pos_inc32 < len32)) begin
            a_v     = 1'b1;
            res_a   = xesp_pkg::make_result(xesp_pkg::KIND_NOTE_ON, chan_q, first_q,
                                            second_q, acc_dur);
            acc_d   = 32'd0;
            phase_d = xesp_pkg::PH_DELAY;
          end else begin
            acc_d = acc_dur;
          end
        end
        xesp_pkg::PH_MTYPE: begin
          first_d = b;
          pos_d   = pos_inc;
          phase_d = xesp_pkg::PH_MSIZE;
        end
        xesp_pkg::PH_MSIZE: begin
          second_d = b;
          pos_d    = pos_inc;
          if (!msz.known || msz.size != b) begin
            fin_d = 1'b1;
            a_v   = 1'b1;
            res_a = xesp_pkg::make_result(xesp_pkg::KIND_ERROR, 4'd0, first_q, b,
                                          32'd0);
          end else if (b == 8'd0) begin
            fin_d = 1'b1;
            a_v   = 1'b1;
            res_a = xesp_pkg::make_result(xesp_pkg::KIND_END, 4'd0, first_q, 8'd0,
                                          32'd0);
          end else begin
            mleft_d = b;
            acc_d   = 32'd0;
            phase_d = xesp_pkg::PH_MDATA;
          end
        end
        xesp_pkg::PH_MDATA: begin
          pos_d   = pos_inc;
          mleft_d = mleft_dec;
          if (mleft_dec == 8'd0) begin
            a_v     = 1'b1;
            res_a   = xesp_pkg::make_result(
                        (first_q == xesp_pkg::MetaTempo) ? xesp_pkg::KIND_TEMPO
                                                         : xesp_pkg::KIND_META,
                        4'd0, first_q, 8'd0, acc_meta);
            acc_d   = 32'd0;
            phase_d = xesp_pkg::PH_DELAY;
          end else begin
            acc_d = acc_meta;
          end
        end
        default: begin
          phase_d   = xesp_pkg::PH_STATUS;
          do_status = 1'b1;
        end
      endcase

      // Status byte handling, shared by the status phase and a broken delay.
      if (do_status) begin
        if (pos32 >= len32) begin
          fin_d = 1'b1;
        end else if (left32 < 32'd3) begin
          fin_d = 1'b1;
          b_v   = 1'b1;
        end else begin
          pos_d = pos_inc;
          if (b[7]) begin
            if (b == xesp_pkg::ByteMeta) begin
              phase_d = xesp_pkg::PH_MTYPE;
            end else begin
              cmd_d  = b[7:4];
              chan_d = b[3:0];
              if (b[7:4] == xesp_pkg::CmdCtl || b[7:4] == xesp_pkg::CmdBend ||
                  b[7:4] == xesp_pkg::CmdProgram || b[7:4] == xesp_pkg::CmdNote) begin
                phase_d = xesp_pkg::PH_FIRST;
              end else begin
                fin_d = 1'b1;
                b_v   = 1'b1;
                res_b = xesp_pkg::make_result(xesp_pkg::KIND_ERROR, b[3:0], b, 8'd0,
                                              32'd0);
              end
            end
          end
        end
      end
    end
  end

  // Pack the results of this byte into one queue entry.
  always_comb begin
    entry_o.two  = a_v && b_v;
    entry_o.res0 = a_v ? res_a : res_b;
    entry_o.res1 = res_b;
  end
  assign push_o = accept && (a_v || b_v);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i) begin
      len_q <= xesp_pkg::LenBits'(sequence_length_i);
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= xesp_pkg::PH_STATUS;
      fin_q    <= 1'b0;
      cmd_q    <= '0;
      chan_q   <= '0;
      first_q  <= '0;
      second_q <= '0;
      acc_q    <= '0;
      mleft_q  <= '0;
    end else if (accept) begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      cmd_q    <= cmd_d;
      chan_q   <= chan_d;
      first_q  <= first_d;
      second_q <= second_d;
      acc_q    <= acc_d;
      mleft_q  <= mleft_d;
    end
  end

endmodule

// ----- rtl/core/xesp_queue.sv -----
// ----------------------------------------------------------------------------
// xesp_queue
// Short FIFO of result entries between the decoder and the output stage.
// ----------------------------------------------------------------------------
module xesp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  xesp_pkg::entry_t entry_i,
  input  logic             pop_i,
  output xesp_pkg::entry_t head_o,
  output logic             empty_o,
  output logic             full_o
);

  xesp_pkg::entry_t                  mem_q [xesp_pkg::QueueDepth];
  logic [xesp_pkg::QueuePtrBits-1:0] wr_q, rd_q;
  logic [xesp_pkg::QueuePtrBits:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (xesp_pkg::QueuePtrBits+1)'(xesp_pkg::QueueDepth));
  assign head_o  = mem_q[rd_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ----- rtl/core/xesp_back.sv -----
// ----------------------------------------------------------------------------
// xesp_back
// Output stage: walks each queue entry one result at a time into the
// output register and marks the final result of every byte.
// ----------------------------------------------------------------------------
module xesp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xesp_pkg::entry_t  head_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output xesp_pkg::result_t out_o,
  output logic              last_o
);

  logic              valid_q, valid_d;
  logic              sel_q;
  logic              load;
  xesp_pkg::result_t out_q;
  logic              last_q;

  // Load when a result is waiting and the register is free or draining.
  assign load    = !empty_i && (!valid_q || !out_stall_i);
  assign pop_o   = load && (!head_i.two || sel_q);
  assign valid_d = load ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (load) begin
        sel_q <= head_i.two && !sel_q;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q  <= sel_q ? head_i.res1 : head_i.res0;
      last_q <= !head_i.two || sel_q;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/core/xmi_event_stream_parser_top.sv -----
// ----------------------------------------------------------------------------
// xmi_event_stream_parser_top
// Extended MIDI event chunk parser: bytes in, decoded events out.
// ----------------------------------------------------------------------------
// The parser takes one byte of the event chunk in every cycle. A byte causes
// zero, one or two results; they are queued in a four-entry FIFO as one entry
// and leave through the output register one result per cycle while the output
// is not stalled. A result is written into the FIFO when its byte is taken
// and then loaded into the output register. The input stalls only while the
// FIFO is full.
// The sequence length register is written through the configuration channel,
// which is always ready; write it only while the parser is idle.
`include "assert_macros.svh"

module xmi_event_stream_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] sequence_length_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_sequence_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [3:0]  channel_o,
  output logic [7:0]  first_data_o,
  output logic [7:0]  second_data_o,
  output logic [31:0] value_o,
  output logic        last_o
);

  logic              push, pop, q_empty, q_full;
  xesp_pkg::entry_t  entry, head;
  xesp_pkg::result_t out_res;

  assign cfg_ready_o = 1'b1;

  // Decoder.
  xesp_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .sequence_length_i  (sequence_length_i),
    .in_valid_i         (in_valid_i),
    .data_byte_i        (data_byte_i),
    .start_of_sequence_i(start_of_sequence_i),
    .q_full_i           (q_full),
    .in_stall_o         (in_stall_o),
    .push_o             (push),
    .entry_o            (entry)
  );

  // Result queue.
  xesp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // Output stage.
  xesp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_res),
    .last_o     (last_o)
  );

  assign kind_o        = out_res.kind;
  assign channel_o     = out_res.channel;
  assign first_data_o  = out_res.first_data;
  assign second_data_o = out_res.second_data;
  assign value_o       = out_res.value;

  // The decoder never writes into a full queue.
  `ASSERT_RST(a_no_overflow, clk_i, rst_ni, push |-> !q_full)
  // The second result of a byte follows its first transfer directly.
  `ASSERT_RST(a_pair_follows, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
  // Nothing reaches the output without passing through the queue.
  `ASSERT_RST(a_empty_idle, clk_i, rst_ni, q_empty && !out_valid_o |=> !out_valid_o)
  // The output register is empty once reset has been applied.
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o)

endmodule
